[sv/assert_macros.svh]
// Assertion macros shared by the RTL modules of the completion queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in completion queue");

// Checks that a condition never holds while rst_n is high.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition in completion queue");

`endif

[sv/iocq_pkg.sv]
// Shared constants, types and codes of the in-order completion queue.
package iocq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_W    = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int FUNC_W      = 2;
    localparam int HANDLE_FIELD_W = 16;
    localparam int OCC_W       = 5;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DONE_OK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DONE_ERR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_IDLE     = 2'd3;

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [ID_W-1:0]     id_t;

    typedef struct packed {
        logic load;
        logic find;
        logic apply;
        logic retire;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
    } status_t;

endpackage

[sv/iocq_ctrl.sv]
// Controller state machine that sequences each transaction through the datapath.
`include "assert_macros.svh"

module iocq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  iocq_pkg::status_t  status,
    output iocq_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIND   = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_RETIRE = 3'd3;
    localparam logic [2:0] ST_PUSH   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = status.is_alloc ? ST_PUSH : ST_RETIRE;
            end
            ST_RETIRE:
            begin
                cmd.retire = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // The result register may still hold an earlier result.
                if (!m_valid_reg || m_tready)
                begin
                    cmd.push     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_CLK(a_push_shows_result, cmd.push |=> m_tvalid)
    `ASSERT_CLK(a_no_overwrite, (state_reg == ST_PUSH && m_valid_reg && !m_tready)
        |=> (state_reg == ST_PUSH))
    `ASSERT_NEVER(a_push_while_blocked, cmd.push && m_valid_reg && !m_tready)

endmodule

[sv/iocq_datapath.sv]
// Datapath of the completion queue: entry cells, id search, compaction and result.
`include "assert_macros.svh"

module iocq_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  iocq_pkg::cmd_t                      cmd,
    output iocq_pkg::status_t                   status,
    input  logic [iocq_pkg::FUNC_W-1:0]         in_func,
    input  logic [iocq_pkg::IN_TDATA_W-1:0]     in_data,
    output logic [iocq_pkg::OUT_TDATA_W-1:0]    out_data
);

    localparam int D = iocq_pkg::QUEUE_DEPTH;

    logic [iocq_pkg::FUNC_W-1:0] func_reg, func_next;
    iocq_pkg::id_t               req_reg, req_next;
    iocq_pkg::handle_t           hin_reg, hin_next;
    logic                        busy_reg, busy_next;

    iocq_pkg::id_t               slot_id_reg [D];
    iocq_pkg::id_t               slot_id_next [D];
    iocq_pkg::handle_t           slot_handle_reg [D];
    iocq_pkg::handle_t           slot_handle_next [D];
    logic [D-1:0]                done_reg, done_next;
    logic [iocq_pkg::CNT_W-1:0]  count_reg, count_next;
    iocq_pkg::id_t               idc_reg, idc_next;

    logic                        found_reg, found_next;
    logic [iocq_pkg::IDX_W-1:0]  pos_reg, pos_next;

    iocq_pkg::id_t               new_id_reg, new_id_next;
    logic                        refused_reg, refused_next;
    logic                        nf_reg, nf_next;
    logic                        retired_reg, retired_next;
    logic [iocq_pkg::HANDLE_FIELD_W-1:0] rh_reg, rh_next;
    logic [iocq_pkg::OUT_TDATA_W-1:0]    out_reg, out_next;

    logic                        remove_en;
    logic [iocq_pkg::IDX_W-1:0]  pos_sel;
    iocq_pkg::id_t               id_inc;
    logic [D-1:0]                live_mask;

    assign status.is_alloc = (func_reg == iocq_pkg::FUNC_ALLOC);
    assign out_data        = out_reg;
    assign id_inc          = idc_reg + 32'd1;

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            live_mask[i] = (iocq_pkg::CNT_W'(i) < count_reg);
        end
    end

    always_comb
    begin
        func_next    = func_reg;
        req_next     = req_reg;
        hin_next     = hin_reg;
        busy_next    = busy_reg;
        slot_id_next     = slot_id_reg;
        slot_handle_next = slot_handle_reg;
        done_next    = done_reg;
        count_next   = count_reg;
        idc_next     = idc_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        new_id_next  = new_id_reg;
        refused_next = refused_reg;
        nf_next      = nf_reg;
        retired_next = retired_reg;
        rh_next      = rh_reg;
        out_next     = out_reg;
        remove_en    = 1'b0;
        pos_sel      = pos_reg;

        if (cmd.load)
        begin
            func_next    = in_func;
            req_next     = in_data[31:0];
            hin_next     = iocq_pkg::handle_t'(in_data[47:32]);
            busy_next    = in_data[48];
            new_id_next  = '0;
            refused_next = 1'b0;
            nf_next      = 1'b0;
            retired_next = 1'b0;
            rh_next      = '0;
        end

        if (cmd.find)
        begin
            // The hit nearest the head wins.
            found_next = 1'b0;
            pos_next   = '0;
            for (int i = D - 1; i >= 0; i--)
            begin
                if (live_mask[i] && (slot_id_reg[i] == req_reg))
                begin
                    found_next = 1'b1;
                    pos_next   = iocq_pkg::IDX_W'(i);
                end
            end
        end

        if (cmd.apply)
        begin
            case (func_reg)
                iocq_pkg::FUNC_ALLOC:
                begin
                    if (count_reg == iocq_pkg::CNT_W'(D))
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        idc_next    = (id_inc == '0) ? 32'd1 : id_inc;
                        new_id_next = (id_inc == '0) ? 32'd1 : id_inc;
                        slot_id_next[count_reg[iocq_pkg::IDX_W-1:0]] =
                            (id_inc == '0) ? 32'd1 : id_inc;
                        done_next[count_reg[iocq_pkg::IDX_W-1:0]] = 1'b0;
                        count_next  = count_reg + iocq_pkg::CNT_W'(1);
                    end
                end
                iocq_pkg::FUNC_DONE_OK:
                begin
                    if (found_reg)
                    begin
                        done_next[pos_reg]        = 1'b1;
                        slot_handle_next[pos_reg] = hin_reg;
                    end
                    else
                    begin
                        nf_next = 1'b1;
                    end
                end
                iocq_pkg::FUNC_DONE_ERR:
                begin
                    if (found_reg)
                    begin
                        remove_en = 1'b1;
                    end
                    else
                    begin
                        nf_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.retire)
        begin
            if (!busy_reg && (count_reg != '0) && done_reg[0])
            begin
                retired_next = 1'b1;
                rh_next      = iocq_pkg::HANDLE_FIELD_W'(slot_handle_reg[0]);
                remove_en    = 1'b1;
                pos_sel      = '0;
            end
        end

        if (remove_en)
        begin
            // Every cell at or behind the removed one takes its successor.
            for (int i = 0; i < D; i++)
            begin
                if (iocq_pkg::IDX_W'(i) >= pos_sel)
                begin
                    if (i < D - 1)
                    begin
                        slot_id_next[i]     = slot_id_reg[(i + 1) % D];
                        slot_handle_next[i] = slot_handle_reg[(i + 1) % D];
                        done_next[i]        = done_reg[(i + 1) % D];
                    end
                    else
                    begin
                        done_next[i] = 1'b0;
                    end
                end
            end
            count_next = count_reg - iocq_pkg::CNT_W'(1);
        end

        if (cmd.push)
        begin
            out_next = {iocq_pkg::OCC_W'(count_reg), rh_reg, retired_reg,
                        nf_reg, refused_reg, new_id_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            count_reg <= '0;
            idc_reg   <= '0;
        end
        else
        begin
            done_reg  <= done_next;
            count_reg <= count_next;
            idc_reg   <= idc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        req_reg      <= req_next;
        hin_reg      <= hin_next;
        busy_reg     <= busy_next;
        slot_id_reg     <= slot_id_next;
        slot_handle_reg <= slot_handle_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        new_id_reg   <= new_id_next;
        refused_reg  <= refused_next;
        nf_reg       <= nf_next;
        retired_reg  <= retired_next;
        rh_reg       <= rh_next;
        out_reg      <= out_next;
    end

    `ASSERT_NEVER(a_count_bound, count_reg > iocq_pkg::CNT_W'(D))
    `ASSERT_NEVER(a_done_only_live, (done_reg & ~live_mask) != '0)
    `ASSERT_CLK(a_retire_needs_done, cmd.retire && !busy_reg && done_reg[0]
        |=> (count_reg == $past(count_reg) - iocq_pkg::CNT_W'(1)))

endmodule

[sv/in_order_completion_queue.sv]
// Top level of the in-order completion queue: controller and datapath joined.
//
// The block keeps up to 16 outstanding requests in allocation order in a chain
// of entry cells, the head at cell 0. Each transaction passes through capture,
// id search, update, retirement and result write before the block is ready again,
// the controller stepping one item at a time through the shared compaction
// network; an allocate skips the retirement step. Every transaction yields exactly
// one result. The result is held in an output register, so the next transaction
// is accepted while an earlier result waits; the write of a new result waits only
// if the previous one has still not been taken. A search compares every live cell
// at once and picks the match nearest the head; a failed completion or a
// retirement closes the gap by shifting the cells behind it one place toward the
// head. Ids start at 1, wrap and skip 0. No clearing pass follows reset.
`include "assert_macros.svh"

module in_order_completion_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tuser: func[1:0]
    input  logic [iocq_pkg::FUNC_W-1:0]         s_tuser,
    // s_tdata: req_id[31:0], payload_handle[47:32], consumer_busy[48], zero[55:49]
    input  logic [iocq_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: new_id[31:0], alloc_refused[32], id_not_found[33],
    //          retire_valid[34], retire_handle[50:35], occupancy[55:51]
    output logic [iocq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    iocq_pkg::cmd_t    cmd;
    iocq_pkg::status_t status;

    iocq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iocq_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_func  (s_tuser),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

    // A transaction is only taken while no other is being worked on.
    `ASSERT_NEVER(a_accept_only_idle, s_tvalid && s_tready && (cmd.find || cmd.apply))

endmodule

[dv/tb_in_order_completion_queue.sv]
// Self-checking testbench of the in-order completion queue, with its own queue predictor.
module tb_in_order_completion_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import iocq_pkg::*;

    // Cycles without any transaction on either side before the run is abandoned.
    // The slowest legal stretch is a sender gap or a receiver stall plus the
    // processing of one transaction, so this leaves a wide margin.
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int SETTLE_CYCLES = 20;

    // One request as the sender presents it. A pause entry carries no request: it
    // tells the driver to hold off until every outstanding reply has arrived.
    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        id_t                       req_id;
        logic [HANDLE_FIELD_W-1:0] handle;
        logic                      busy;
        logic                      pause;
    } request_t;

    // One reply, laid out exactly as m_tdata, the last member in the lowest bits.
    typedef struct packed {
        logic [OCC_W-1:0]          occupancy;
        logic [HANDLE_FIELD_W-1:0] retire_handle;
        logic                      retire_valid;
        logic                      id_not_found;
        logic                      alloc_refused;
        id_t                       new_id;
    } reply_t;

    // Contents of the queue: entry 0 is the head.
    typedef struct packed {
        logic [QUEUE_DEPTH-1:0][ID_W-1:0]     ids;
        logic [QUEUE_DEPTH-1:0]               done;
        logic [QUEUE_DEPTH-1:0][HANDLE_W-1:0] handles;
        logic [CNT_W-1:0]                     count;
        id_t                                  last_id;
    } queue_state_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [FUNC_W-1:0]      s_tuser = '0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    request_t     pending_requests[$];
    reply_t       expected_replies[$];
    queue_state_t stimulus_queue;
    queue_state_t predicted_queue;
    request_t     current_request;
    int           requests_total = 0;
    int           requests_taken = 0;
    int           error_count = 0;
    int           quiet_cycles = 0;
    logic         took = 1'b0;
    logic         pause_hold = 1'b0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           ready_mode = 0;
    int           ready_mode_left = 0;
    int           ready_phase = 0;

    in_order_completion_queue i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Takes the entry at pos out of the queue and moves everything behind it one
    // place towards the head.
    function automatic void drop_entry(inout queue_state_t st, input int pos);
        int i;
        for (i = pos; i + 1 < st.count; i++)
        begin
            st.ids[i]     = st.ids[i + 1];
            st.done[i]    = st.done[i + 1];
            st.handles[i] = st.handles[i + 1];
        end
        st.count = st.count - CNT_W'(1);
        st.done[st.count] = 1'b0;
    endfunction

    // Applies one request to a copy of the queue and returns the reply it causes.
    function automatic reply_t advance_queue(inout queue_state_t st, input request_t rq);
        reply_t rp;
        int     pos;
        int     i;
        logic   try_retire;
        rp = '0;
        pos = -1;
        try_retire = 1'b1;
        case (rq.func)
            FUNC_ALLOC:
            begin
                // An allocate never retires anything.
                try_retire = 1'b0;
                if (st.count >= QUEUE_DEPTH)
                begin
                    rp.alloc_refused = 1'b1;
                end
                else
                begin
                    st.last_id = st.last_id + id_t'(1);
                    if (st.last_id == '0)
                    begin
                        st.last_id = 1;
                    end
                    st.ids[st.count]  = st.last_id;
                    st.done[st.count] = 1'b0;
                    st.count = st.count + CNT_W'(1);
                    rp.new_id = st.last_id;
                end
            end
            FUNC_DONE_OK, FUNC_DONE_ERR:
            begin
                // The match nearest the head wins.
                for (i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (pos < 0 && i < st.count && st.ids[i] == rq.req_id)
                    begin
                        pos = i;
                    end
                end
                if (pos < 0)
                begin
                    rp.id_not_found = 1'b1;
                end
                else if (rq.func == FUNC_DONE_OK)
                begin
                    st.done[pos]    = 1'b1;
                    st.handles[pos] = rq.handle[HANDLE_W-1:0];
                end
                else
                begin
                    drop_entry(st, pos);
                end
            end
            default:
            begin
            end
        endcase
        if (try_retire && !rq.busy && st.count > 0 && st.done[0])
        begin
            rp.retire_valid  = 1'b1;
            rp.retire_handle = st.handles[0];
            drop_entry(st, 0);
        end
        rp.occupancy = st.count;
        return rp;
    endfunction

    // Queues one request for the driver. A separate copy of the queue follows the
    // stimulus so that completions can be aimed at ids that are really queued.
    task automatic push_request(input logic [FUNC_W-1:0] func, input id_t req_id,
                                input logic [HANDLE_FIELD_W-1:0] handle, input logic busy);
        request_t rq;
        reply_t   ignored;
        rq = '{func: func, req_id: req_id, handle: handle, busy: busy, pause: 1'b0};
        ignored = advance_queue(stimulus_queue, rq);
        pending_requests.push_back(rq);
        requests_total++;
    endtask

    task automatic push_pause();
        request_t rq;
        rq = '0;
        rq.pause = 1'b1;
        pending_requests.push_back(rq);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Stimulus, then the wait for the last reply and the verdict.
    initial
    begin : stimulus
        int   i;
        int   r;
        int   alloc_pct;
        int   idx;
        id_t  target;
        logic [FUNC_W-1:0] func;

        stimulus_queue = '0;
        predicted_queue = '0;

        // Directed part. Fill the queue to the brim, then one allocate too many,
        // which must be refused without using up an id.
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            push_request(FUNC_ALLOC, '0, '0, 1'b0);
        end
        push_request(FUNC_ALLOC, '1, '1, 1'b1);
        // Completion behind the head: stored, but nothing may retire.
        push_request(FUNC_DONE_OK, 32'd2, 16'hFFFF, 1'b0);
        // Head completes while the consumer is busy, then again with a new handle,
        // which must overwrite the first.
        push_request(FUNC_DONE_OK, 32'd1, 16'h0000, 1'b1);
        push_request(FUNC_DONE_OK, 32'd1, 16'h1234, 1'b1);
        // The consumer becomes idle twice: each event retires one entry.
        push_request(FUNC_IDLE, '0, '0, 1'b0);
        push_request(FUNC_IDLE, '1, '1, 1'b0);
        // A failed completion takes the new head out without retiring anything.
        push_request(FUNC_DONE_ERR, 32'd3, 16'hA5A5, 1'b0);
        // Unknown ids at both ends of the range.
        push_request(FUNC_DONE_OK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        push_request(FUNC_DONE_ERR, 32'h0000_0000, 16'h0000, 1'b0);
        push_pause();

        // Random part. The share of allocates moves between phases so that the
        // queue spends time nearly empty, half full and full.
        alloc_pct = 45;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 120 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       alloc_pct = 20;
                    1:       alloc_pct = 45;
                    default: alloc_pct = 75;
                endcase
            end
            if (i % 400 == 399)
            begin
                push_pause();
            end
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
            begin
                push_request(FUNC_ALLOC, $urandom,
                             HANDLE_FIELD_W'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                begin
                    func = FUNC_IDLE;
                end
                else if (r < 75)
                begin
                    func = FUNC_DONE_OK;
                end
                else
                begin
                    func = FUNC_DONE_ERR;
                end
                // Most completions name a queued entry, often the head; the rest
                // name ids that are gone, not given yet, or anything at all.
                if (stimulus_queue.count > 0 && $urandom_range(0, 4) != 0)
                begin
                    idx = ($urandom_range(0, 1) == 0) ? 0 :
                          $urandom_range(0, stimulus_queue.count - 1);
                    target = stimulus_queue.ids[idx];
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       target = stimulus_queue.last_id + $urandom_range(1, 3);
                        1:       target = stimulus_queue.last_id - $urandom_range(0, 20);
                        default: target = $urandom;
                    endcase
                end
                push_request(func, target, HANDLE_FIELD_W'($urandom_range(0, 65535)),
                             ($urandom_range(0, 3) == 0));
            end
        end

        // Wait for every request to be taken and every reply to arrive, then let
        // the block settle for SETTLE_CYCLES in case anything stray comes out.
        do
        begin
            @(negedge clk);
        end
        while (requests_taken != requests_total || expected_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Reset is held low from the start and released on a falling edge.
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Sender: requests go out in bursts of random length with random gaps between
    // them. A request stays on the bus until the block takes it. A pause
    // entry keeps the bus quiet until nothing is outstanding.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !took)
            begin
                // Still waiting for the block to take the current request.
            end
            else if (pause_hold)
            begin
                s_tvalid <= 1'b0;
                if (expected_replies.size() == 0)
                begin
                    pause_hold = 1'b0;
                end
            end
            else if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_requests.size() > 0)
            begin
                current_request = pending_requests[0];
                pending_requests.delete(0);
                if (current_request.pause)
                begin
                    s_tvalid <= 1'b0;
                    pause_hold = 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= current_request.func;
                    s_tdata  <= {7'b0, current_request.busy, current_request.handle,
                                 current_request.req_id};
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: readiness follows a pattern that changes every so often between
    // always ready, random, mostly stalled and a fixed one-in-three rhythm.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                ready_mode_left = $urandom_range(20, 200);
            end
            else
            begin
                ready_mode_left = ready_mode_left - 1;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 7) == 0);
                default:
                begin
                    m_tready <= (ready_phase == 0);
                    ready_phase = (ready_phase + 1) % 3;
                end
            endcase
        end
    end

    // Input side: each accepted request is run through the predictor at once and
    // its reply joins the back of the expected store.
    always @(posedge clk)
    begin
        took <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            expected_replies.push_back(advance_queue(predicted_queue, current_request));
            requests_taken <= requests_taken + 1;
        end
    end

    // Output side: every reply transaction is checked against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin : reply_check
        reply_t act;
        reply_t exp_rp;
        if (m_tvalid && m_tready)
        begin
            act = reply_t'(m_tdata);
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply: expected none, actual 0x%0h",
                         $time, m_tdata);
                error_count++;
            end
            else
            begin
                exp_rp = expected_replies[0];
                expected_replies.delete(0);
                check_field("new_id", exp_rp.new_id, act.new_id);
                check_field("alloc_refused", 32'(exp_rp.alloc_refused),
                            32'(act.alloc_refused));
                check_field("id_not_found", 32'(exp_rp.id_not_found),
                            32'(act.id_not_found));
                check_field("retire_valid", 32'(exp_rp.retire_valid),
                            32'(act.retire_valid));
                check_field("retire_handle", 32'(exp_rp.retire_handle),
                            32'(act.retire_handle));
                check_field("occupancy", 32'(exp_rp.occupancy), 32'(act.occupancy));
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either side means the block
    // has hung.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d replies outstanding",
                         $time, STALL_LIMIT, expected_replies.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

[files.f]
+incdir+sv
sv/iocq_pkg.sv
sv/iocq_ctrl.sv
sv/iocq_datapath.sv
sv/in_order_completion_queue.sv
dv/tb_in_order_completion_queue.sv
